### hw/rtl/ppdc_pkg.sv
// Shared types, widths and register codes for the positional/incremental PID controller.
package ppdc_pkg;

    // Sample and gain format
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 24;
    localparam int ILIM_W         = 20;
    localparam int OLIM_W         = 15;
    localparam int DRIVE_W        = 16;

    // Error history and integral store
    localparam int ERR_W   = SAMPLE_WIDTH + 1;
    localparam int SUM_W   = ILIM_W + 1;
    localparam int SUMX_W  = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;

    // Multiplier operands and products
    localparam int OPD_W   = ((ERR_W + 2) > SUM_W) ? (ERR_W + 2) : SUM_W;
    localparam int PROD_W  = OPD_W + GAIN_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SH_W    = ACC_W - GAIN_FRAC_BITS;
    localparam int DRVX_W  = SH_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;
    localparam int CFG_DATA_W = GAIN_W;

    // Loop modes and commands
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;
    localparam logic CMD_RUN          = 1'b0;
    localparam logic CMD_CLEAR        = 1'b1;

    // Register reset values
    localparam logic [ILIM_W-1:0] ILIM_RESET = 20'd1000;
    localparam logic [OLIM_W-1:0] OLIM_RESET = 15'd9999;

    // Programmed settings
    typedef struct packed {
        logic              loop_mode;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [ILIM_W-1:0] integral_limit;
        logic [OLIM_W-1:0] output_limit;
    } ppdc_cfg_t;

    // One classified step between front and back
    typedef struct packed {
        logic                    clear;
        logic                    mode;
        logic signed [OPD_W-1:0] opd_p;
        logic signed [OPD_W-1:0] opd_i;
        logic signed [OPD_W-1:0] opd_d;
    } ppdc_op_t;

endpackage

### hw/rtl/pid_position_delta_controller.sv
// Top level: configuration registers, front end, step queue and back end.
// An accepted input beat passes the queue entry and the product, scaled-sum and output stages.
// Throughput: one beat per cycle while out_stall is low; held add and clamp loop is in one stage.
// The front end accepts while the 4-entry queue has room, independent of output stall.
// Reset (rst_n, async, active low) clears error history, integral sum, held output and
// pipeline valids; registers return to mode positional, gains 0, limits 1000 and 9999.
module pid_position_delta_controller
    import ppdc_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0] feedback,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [DRIVE_W-1:0]      drive,
    output logic                           drive_saturated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    ppdc_cfg_t cfg_reg;
    ppdc_op_t  push_op, pop_op;
    logic      push, pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loop_mode      <= MODE_POSITIONAL;
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_limit <= ILIM_RESET;
            cfg_reg.output_limit   <= OLIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOOP_MODE:      cfg_reg.loop_mode      <= cfg_data[0];
                REG_GAIN_P:         cfg_reg.gain_p         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:         cfg_reg.gain_i         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:         cfg_reg.gain_d         <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_data[ILIM_W-1:0];
                REG_OUTPUT_LIMIT:   cfg_reg.output_limit   <= cfg_data[OLIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input handshake
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    ppdc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .command  (command),
        .setpoint (setpoint),
        .feedback (feedback),
        .op       (push_op)
    );

    ppdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_op),
        .pop       (pop),
        .pop_data  (pop_op),
        .full      (q_full),
        .empty     (q_empty)
    );

    ppdc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .op_valid        (!q_empty),
        .op              (pop_op),
        .op_pop          (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .drive           (drive),
        .drive_saturated (drive_saturated)
    );

endmodule

### hw/rtl/ppdc_front.sv
// Front end: takes input beats, tracks the error history and forms the multiplier operands.
module ppdc_front
    import ppdc_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ppdc_cfg_t                      cfg,
    input  logic                           push,
    input  logic                           command,
    input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0] feedback,
    output ppdc_op_t                       op
);

    logic signed [ERR_W-1:0]  e1_reg, e1_next;
    logic signed [ERR_W-1:0]  e2_reg, e2_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W:0]     d1;
    logic signed [ERR_W+1:0]   d2;
    logic signed [SUMX_W-1:0]  sum_raw;
    logic signed [SUMX_W-1:0]  lim;
    logic signed [SUM_W-1:0]   sum_clamped;

    // Error terms
    always_comb
    begin
        err     = ERR_W'(setpoint) - ERR_W'(feedback);
        d1      = (ERR_W+1)'(err) - (ERR_W+1)'(e1_reg);
        d2      = (ERR_W+2)'(err) - ((ERR_W+2)'(e1_reg) <<< 1) + (ERR_W+2)'(e2_reg);
        sum_raw = SUMX_W'(sum_reg) + SUMX_W'(err);
        lim     = $signed(SUMX_W'(cfg.integral_limit));
        if (sum_raw > lim)
        begin
            sum_clamped = SUM_W'(lim);
        end
        else if (sum_raw < -lim)
        begin
            sum_clamped = SUM_W'(-lim);
        end
        else
        begin
            sum_clamped = SUM_W'(sum_raw);
        end
    end

    // Operand selection per loop mode
    always_comb
    begin
        op.clear = command;
        op.mode  = cfg.loop_mode;
        if (cfg.loop_mode == MODE_INCREMENTAL)
        begin
            op.opd_p = OPD_W'(d1);
            op.opd_i = OPD_W'(err);
            op.opd_d = OPD_W'(d2);
        end
        else
        begin
            op.opd_p = OPD_W'(err);
            op.opd_i = OPD_W'(sum_clamped);
            op.opd_d = OPD_W'(d1);
        end
    end

    // History update on each accepted beat
    always_comb
    begin
        e1_next  = e1_reg;
        e2_next  = e2_reg;
        sum_next = sum_reg;
        if (push)
        begin
            if (command == CMD_CLEAR)
            begin
                e1_next  = '0;
                e2_next  = '0;
                sum_next = '0;
            end
            else
            begin
                e1_next = err;
                e2_next = e1_reg;
                if (cfg.loop_mode == MODE_POSITIONAL)
                begin
                    sum_next = sum_clamped;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg  <= '0;
            e2_reg  <= '0;
            sum_reg <= '0;
        end
        else
        begin
            e1_reg  <= e1_next;
            e2_reg  <= e2_next;
            sum_reg <= sum_next;
        end
    end

endmodule

### hw/rtl/ppdc_queue.sv
// Short FIFO of classified steps between the front and back ends.
module ppdc_queue
    import ppdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ppdc_op_t push_data,
    input  logic     pop,
    output ppdc_op_t pop_data,
    output logic     full,
    output logic     empty
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    ppdc_op_t               mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/ppdc_back.sv
// Back end: gain multiplies, scaled sum, held-output add and output clamp.
module ppdc_back
    import ppdc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ppdc_cfg_t                 cfg,
    input  logic                      op_valid,
    input  ppdc_op_t                  op,
    output logic                      op_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      drive_saturated
);

    // Stage 1: products
    logic                     v1_reg;
    logic                     clr1_reg, mode1_reg;
    logic signed [PROD_W-1:0] pp_reg, pi_reg, pd_reg;
    // Stage 2: scaled sum
    logic                     v2_reg;
    logic                     clr2_reg, mode2_reg;
    logic signed [SH_W-1:0]   sh_reg;
    // Stage 3: output and held value
    logic                     out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic                     sat_reg, sat_next;
    logic signed [DRIVE_W-1:0] held_reg;

    logic signed [GAIN_W:0]   kp, ki, kd;
    logic signed [PROD_W-1:0] pp, pi, pd;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SH_W-1:0]   sh;
    logic signed [DRVX_W-1:0] dx, lim;
    logic                     load3, adv2, adv1;

    // Pipeline flow
    assign load3  = v2_reg && (!out_valid_reg || !out_stall);
    assign adv2   = !v2_reg || load3;
    assign adv1   = !v1_reg || adv2;
    assign op_pop = op_valid && adv1;

    // Gain multiplies
    always_comb
    begin
        kp = $signed({1'b0, cfg.gain_p});
        ki = $signed({1'b0, cfg.gain_i});
        kd = $signed({1'b0, cfg.gain_d});
        pp = PROD_W'(op.opd_p) * PROD_W'(kp);
        pi = PROD_W'(op.opd_i) * PROD_W'(ki);
        pd = PROD_W'(op.opd_d) * PROD_W'(kd);
    end

    // Sum and floor shift
    always_comb
    begin
        acc = ACC_W'(pp_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg);
        sh  = SH_W'(acc >>> GAIN_FRAC_BITS);
    end

    // Held add in incremental mode, clear to zero and symmetric clamp
    always_comb
    begin
        lim = $signed(DRVX_W'(cfg.output_limit));
        if (mode2_reg == MODE_INCREMENTAL)
        begin
            dx = DRVX_W'(sh_reg) + DRVX_W'(held_reg);
        end
        else
        begin
            dx = DRVX_W'(sh_reg);
        end
        sat_next = 1'b0;
        if (clr2_reg)
        begin
            drive_next = '0;
        end
        else if (dx > lim)
        begin
            drive_next = DRIVE_W'(lim);
            sat_next   = 1'b1;
        end
        else if (dx < -lim)
        begin
            drive_next = DRIVE_W'(-lim);
            sat_next   = 1'b1;
        end
        else
        begin
            drive_next = DRIVE_W'(dx);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= op_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                out_valid_reg <= 1'b1;
                held_reg      <= drive_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            clr1_reg  <= op.clear;
            mode1_reg <= op.mode;
            pp_reg    <= pp;
            pi_reg    <= pi;
            pd_reg    <= pd;
        end
        if (adv2 && v1_reg)
        begin
            clr2_reg  <= clr1_reg;
            mode2_reg <= mode1_reg;
            sh_reg    <= sh;
        end
        if (load3)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive           = drive_reg;
    assign drive_saturated = sat_reg;

endmodule
